// ===== hdl/npc_pkg.sv =====
// shared types and default sizes for the nearest palette color block
// no dependencies; imported by the cell and the top level
package npc_pkg;

	localparam int DEF_NUM_COLORS     = 16;
	localparam int DEF_COMPONENT_BITS = 8;

	// control bits that travel along the cell chain with every beat
	typedef struct packed {
		logic valid;
		logic map;
	} npc_ctl_t;

endpackage

// ===== hdl/npc_in_if.sv =====
// input channel: load or map beat with valid/ready handshake
// depends on nothing; widths come from the instantiating scope
interface npc_in_if #(
	parameter int COMPONENT_BITS = 8,
	parameter int INDEX_BITS     = 4
);
	logic                      valid;
	logic                      ready;
	logic                      action;
	logic [INDEX_BITS-1:0]     entry_index;
	logic [COMPONENT_BITS-1:0] red;
	logic [COMPONENT_BITS-1:0] green;
	logic [COMPONENT_BITS-1:0] blue;

	modport source (output valid, action, entry_index, red, green, blue, input ready);
	modport sink   (input valid, action, entry_index, red, green, blue, output ready);
endinterface

// ===== hdl/npc_out_if.sv =====
// result channel: nearest entry index, color and distance
// depends on nothing; widths come from the instantiating scope
interface npc_out_if #(
	parameter int COMPONENT_BITS = 8,
	parameter int INDEX_BITS     = 4
);
	localparam int DIST_BITS = 2 * COMPONENT_BITS + 2;

	logic                      valid;
	logic                      ready;
	logic [INDEX_BITS-1:0]     best_index;
	logic [COMPONENT_BITS-1:0] best_red;
	logic [COMPONENT_BITS-1:0] best_green;
	logic [COMPONENT_BITS-1:0] best_blue;
	logic [DIST_BITS-1:0]      best_distance;

	modport source (output valid, best_index, best_red, best_green, best_blue,
		best_distance, input ready);
	modport sink   (input valid, best_index, best_red, best_green, best_blue,
		best_distance, output ready);
endinterface

// ===== hdl/npc_cell.sv =====
// one cell of the palette chain: holds one palette entry, computes the
// distance of a passing pixel and updates the running best; uses npc_pkg
module npc_cell #(
	parameter int COMPONENT_BITS = 8,
	parameter int INDEX_BITS     = 4,
	parameter int CELL_INDEX     = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  npc_pkg::npc_ctl_t             ctl_i,
	input  logic [INDEX_BITS-1:0]         idx_i,
	input  logic [3*COMPONENT_BITS-1:0]   pix_i,
	input  logic [INDEX_BITS-1:0]         bidx_i,
	input  logic [3*COMPONENT_BITS-1:0]   bclr_i,
	input  logic [2*COMPONENT_BITS+1:0]   bdist_i,
	output npc_pkg::npc_ctl_t             ctl_o,
	output logic [INDEX_BITS-1:0]         idx_o,
	output logic [3*COMPONENT_BITS-1:0]   pix_o,
	output logic [INDEX_BITS-1:0]         bidx_o,
	output logic [3*COMPONENT_BITS-1:0]   bclr_o,
	output logic [2*COMPONENT_BITS+1:0]   bdist_o
);
	import npc_pkg::*;

	localparam int CB = COMPONENT_BITS;
	localparam int DW = 2 * COMPONENT_BITS + 2;
	localparam logic [INDEX_BITS-1:0] MY_IDX = INDEX_BITS'(CELL_INDEX);

	logic [3*CB-1:0] entry_q;

	npc_ctl_t          ctl_s1;
	logic [INDEX_BITS-1:0] idx_s1;
	logic [3*CB-1:0]   pix_s1;
	logic [INDEX_BITS-1:0] bidx_s1;
	logic [3*CB-1:0]   bclr_s1;
	logic [DW-1:0]     bdist_s1;
	logic [2*CB-1:0]   sq_r_s1, sq_g_s1, sq_b_s1;
	logic [3*CB-1:0]   ent_s1;

	npc_ctl_t          ctl_s2;
	logic [INDEX_BITS-1:0] idx_s2;
	logic [3*CB-1:0]   pix_s2;
	logic [INDEX_BITS-1:0] bidx_s2;
	logic [3*CB-1:0]   bclr_s2;
	logic [DW-1:0]     bdist_s2;

	logic [CB-1:0]     d_r, d_g, d_b;
	logic [DW-1:0]     cand_dist;
	logic              take;

	function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	always_comb begin
		d_r = abs_diff(pix_i[3*CB-1:2*CB], entry_q[3*CB-1:2*CB]);
		d_g = abs_diff(pix_i[2*CB-1:CB], entry_q[2*CB-1:CB]);
		d_b = abs_diff(pix_i[CB-1:0], entry_q[CB-1:0]);
	end

	// palette slot write when a load beat for this index goes by
	always_ff @(posedge clk) begin
		if (adv && ctl_i.valid && !ctl_i.map && idx_i == MY_IDX && CELL_INDEX < (1 << INDEX_BITS)) begin
			entry_q <= pix_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
		end
	end

	// stage 1: squared component differences against the stored entry
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1   <= idx_i;
			pix_s1   <= pix_i;
			bidx_s1  <= bidx_i;
			bclr_s1  <= bclr_i;
			bdist_s1 <= bdist_i;
			sq_r_s1  <= (2*CB)'(d_r) * (2*CB)'(d_r);
			sq_g_s1  <= (2*CB)'(d_g) * (2*CB)'(d_g);
			sq_b_s1  <= (2*CB)'(d_b) * (2*CB)'(d_b);
			ent_s1   <= entry_q;
		end
	end

	// stage 2: sum and compare; strict less keeps the lower index on ties
	always_comb begin
		cand_dist = DW'(sq_r_s1) + DW'(sq_g_s1) + DW'(sq_b_s1);
		take = (CELL_INDEX == 0) || (cand_dist < bdist_s1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s2 <= idx_s1;
			pix_s2 <= pix_s1;
			if (take) begin
				bidx_s2  <= MY_IDX;
				bclr_s2  <= ent_s1;
				bdist_s2 <= cand_dist;
			end else begin
				bidx_s2  <= bidx_s1;
				bclr_s2  <= bclr_s1;
				bdist_s2 <= bdist_s1;
			end
		end
	end

	assign ctl_o   = ctl_s2;
	assign idx_o   = idx_s2;
	assign pix_o   = pix_s2;
	assign bidx_o  = bidx_s2;
	assign bclr_o  = bclr_s2;
	assign bdist_o = bdist_s2;

endmodule

// ===== hdl/nearest_palette_color.sv =====
// a map beat goes through stages 1 and 2 of each cell, then the output register
// throughput: one beat per cycle; each cell holds one entry and passes its beat on
// every cycle, and the whole chain halts only while a result waits to be taken
// reset clears the valid bits of the chain and the output register; palette
// entries hold no reset value and must be loaded before a map reads them
module nearest_palette_color #(
	parameter int NUM_COLORS     = npc_pkg::DEF_NUM_COLORS,
	parameter int COMPONENT_BITS = npc_pkg::DEF_COMPONENT_BITS
) (
	input  logic    clk,
	input  logic    arst_n,
	npc_in_if.sink  pixel,
	npc_out_if.source result
);
	import npc_pkg::*;

	localparam int CB = COMPONENT_BITS;
	localparam int IB = $clog2(NUM_COLORS);
	localparam int DW = 2 * COMPONENT_BITS + 2;
	localparam longint MAX_DIST = 3 * ((64'(1) << CB) - 1) * ((64'(1) << CB) - 1);

	npc_ctl_t        ctl   [NUM_COLORS+1];
	logic [IB-1:0]   idx   [NUM_COLORS+1];
	logic [3*CB-1:0] pix   [NUM_COLORS+1];
	logic [IB-1:0]   bidx  [NUM_COLORS+1];
	logic [3*CB-1:0] bclr  [NUM_COLORS+1];
	logic [DW-1:0]   bdist [NUM_COLORS+1];

	logic            adv;
	logic            out_valid_q;
	logic [IB-1:0]   out_idx_q;
	logic [3*CB-1:0] out_clr_q;
	logic [DW-1:0]   out_dist_q;

	assign adv         = !out_valid_q || result.ready;
	assign pixel.ready = adv;

	assign ctl[0]   = '{valid: pixel.valid, map: pixel.action};
	assign idx[0]   = pixel.entry_index;
	assign pix[0]   = {pixel.red, pixel.green, pixel.blue};
	assign bidx[0]  = '0;
	assign bclr[0]  = '0;
	assign bdist[0] = '0;

	for (genvar i = 0; i < NUM_COLORS; i++) begin : g_cell
		npc_cell #(
			.COMPONENT_BITS(CB),
			.INDEX_BITS    (IB),
			.CELL_INDEX    (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.ctl_i  (ctl[i]),
			.idx_i  (idx[i]),
			.pix_i  (pix[i]),
			.bidx_i (bidx[i]),
			.bclr_i (bclr[i]),
			.bdist_i(bdist[i]),
			.ctl_o  (ctl[i+1]),
			.idx_o  (idx[i+1]),
			.pix_o  (pix[i+1]),
			.bidx_o (bidx[i+1]),
			.bclr_o (bclr[i+1]),
			.bdist_o(bdist[i+1])
		);
	end

	// only map beats leave the chain as results; load beats drop off here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl[NUM_COLORS].valid && ctl[NUM_COLORS].map;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_idx_q  <= bidx[NUM_COLORS];
			out_clr_q  <= bclr[NUM_COLORS];
			out_dist_q <= bdist[NUM_COLORS];
		end
	end

	assign result.valid         = out_valid_q;
	assign result.best_index    = out_idx_q;
	assign result.best_red      = out_clr_q[3*CB-1:2*CB];
	assign result.best_green    = out_clr_q[2*CB-1:CB];
	assign result.best_blue     = out_clr_q[CB-1:0];
	assign result.best_distance = out_dist_q;

	a_rise_from_map: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && ctl[NUM_COLORS].valid && ctl[NUM_COLORS].map))
		else $error("result raised without a map beat at the chain end");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (64'(out_dist_q) <= MAX_DIST))
		else $error("distance beyond three full-scale squares");

	a_chain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ctl[NUM_COLORS]) && $stable(bdist[NUM_COLORS]))
		else $error("chain moved while the result was stalled");

	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> out_valid_q && $stable(out_dist_q))
		else $error("stalled result lost or changed");

endmodule

// ===== tb/npc_tb_pkg.sv =====
// action codes, sizes and the color type shared by the palette testbench files
// depends on npc_pkg for the default palette size and component width
package npc_tb_pkg;

	localparam int NUM_ENTRIES = npc_pkg::DEF_NUM_COLORS;
	localparam int COMP_BITS   = npc_pkg::DEF_COMPONENT_BITS;
	localparam int IDX_BITS    = $clog2(NUM_ENTRIES);
	localparam int DIST_BITS   = 2 * COMP_BITS + 2;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_MAP  = 1'b1;

	typedef struct packed {
		logic [COMP_BITS-1:0] red;
		logic [COMP_BITS-1:0] green;
		logic [COMP_BITS-1:0] blue;
	} rgb_t;

endpackage

// ===== tb/npc_map_checker.sv =====
// watches both channels of nearest_palette_color, keeps a palette copy and
// checks every result beat; depends on npc_tb_pkg and the two channel interfaces
module npc_map_checker (
	input  logic clk,
	input  logic arst_n,
	npc_in_if    pixel,
	npc_out_if   result,
	output int   fail_count,
	output int   pending
);
	import npc_tb_pkg::*;

	typedef struct packed {
		logic [IDX_BITS-1:0]  index;
		rgb_t                 color;
		logic [DIST_BITS-1:0] distance;
	} nearest_t;

	rgb_t     palette_copy [NUM_ENTRIES];
	nearest_t nearest_q [$];
	int       fails = 0;

	function automatic int sq_gap(input logic [COMP_BITS-1:0] a, input logic [COMP_BITS-1:0] b);
		int d;
		d = int'(a) - int'(b);
		return d * d;
	endfunction

	function automatic nearest_t find_nearest(input rgb_t px);
		nearest_t best;
		int       d;
		int       i;
		best = '0;
		for (i = 0; i < NUM_ENTRIES; i++) begin
			d = sq_gap(px.red, palette_copy[i].red) + sq_gap(px.green, palette_copy[i].green)
				+ sq_gap(px.blue, palette_copy[i].blue);
			// strict compare keeps the lowest index on equal distances
			if (i == 0 || d < best.distance) begin
				best.index    = i[IDX_BITS-1:0];
				best.color    = palette_copy[i];
				best.distance = d[DIST_BITS-1:0];
			end
		end
		return best;
	endfunction

	task automatic report_field(input string name, input logic [31:0] want, input logic [31:0] got);
		$display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		nearest_t want;
		if (!arst_n) begin
			nearest_q.delete();
			pending    <= 0;
			fail_count <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (nearest_q.size() == 0) begin
					$display("%0t unexpected result: expected none, got index %0d distance %0d",
						$time, result.best_index, result.best_distance);
					fails++;
				end else begin
					want = nearest_q.pop_front();
					if (result.best_index !== want.index)
						report_field("best_index", want.index, result.best_index);
					if (result.best_red !== want.color.red)
						report_field("best_red", want.color.red, result.best_red);
					if (result.best_green !== want.color.green)
						report_field("best_green", want.color.green, result.best_green);
					if (result.best_blue !== want.color.blue)
						report_field("best_blue", want.color.blue, result.best_blue);
					if (result.best_distance !== want.distance)
						report_field("best_distance", want.distance, result.best_distance);
				end
			end
			if (pixel.valid && pixel.ready) begin
				if (pixel.action == ACT_MAP)
					nearest_q.push_back(find_nearest({pixel.red, pixel.green, pixel.blue}));
				else if (pixel.entry_index < NUM_ENTRIES)
					palette_copy[pixel.entry_index] = {pixel.red, pixel.green, pixel.blue};
			end
			pending    <= nearest_q.size();
			fail_count <= fails;
		end
	end

endmodule

// ===== tb/tb_nearest_palette_color.sv =====
// stimulus and verdict for nearest_palette_color: palette loads, pixel maps,
// random idling on both sides; depends on npc_tb_pkg, the channels and npc_map_checker
module tb_nearest_palette_color;
	import npc_tb_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 2 * NUM_ENTRIES + 10;

	typedef enum int {PAL_RANDOM, PAL_UNIFORM, PAL_LADDER, PAL_CLUSTER} pal_theme_e;

	logic clk;
	logic arst_n;
	logic hold_toggle;
	logic hold_seen;
	int   hold_left;
	int   idle_pct  = 0;
	int   stall_pct = 0;
	int   cycles    = 0;
	int   fail_count;
	int   pending;
	rgb_t shade [NUM_ENTRIES];

	npc_in_if  pixel ();
	npc_out_if result ();

	nearest_palette_color dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel),
		.result (result)
	);

	npc_map_checker nearest_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off whenever hold_toggle flips
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			hold_left    <= 0;
			hold_seen    <= 1'b0;
		end else if (hold_seen != hold_toggle) begin
			hold_seen    <= hold_toggle;
			hold_left    <= HOLD_CYCLES;
			result.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic logic [COMP_BITS-1:0] nudge(input logic [COMP_BITS-1:0] v);
		int t;
		t = int'(v) + int'($urandom_range(12)) - 6;
		if (t < 0)
			t = 0;
		else if (t > 255)
			t = 255;
		return t[COMP_BITS-1:0];
	endfunction

	task automatic send_beat(input logic act, input logic [IDX_BITS-1:0] idx, input rgb_t c);
		while ($urandom_range(99) < idle_pct) begin
			pixel.valid <= 1'b0;
			@(posedge clk);
		end
		pixel.valid       <= 1'b1;
		pixel.action      <= act;
		pixel.entry_index <= idx;
		pixel.red         <= c.red;
		pixel.green       <= c.green;
		pixel.blue        <= c.blue;
		do @(posedge clk); while (!pixel.ready);
	endtask

	task automatic load_entry(input logic [IDX_BITS-1:0] idx, input rgb_t c);
		send_beat(ACT_LOAD, idx, c);
		shade[idx] = c;
	endtask

	task automatic map_pixel(input rgb_t c);
		// entry_index is don't-care on a map beat, so it gets noise
		send_beat(ACT_MAP, IDX_BITS'($urandom), c);
	endtask

	task automatic wait_drained;
		pixel.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic reload_palette(input pal_theme_e theme);
		int   i;
		int   step;
		rgb_t base;
		rgb_t c;
		base = 24'($urandom);
		if (theme == PAL_UNIFORM)
			base = $urandom_range(1) ? '1 : '0;
		for (i = 0; i < NUM_ENTRIES; i++) begin
			case (theme)
				PAL_RANDOM:  c = 24'($urandom);
				PAL_UNIFORM: c = base;
				PAL_LADDER:  c = {3{8'(i * 16)}};
				default:     c = {nudge(base.red), nudge(base.green), nudge(base.blue)};
			endcase
			load_entry(i[IDX_BITS-1:0], c);
		end
		// opposite corner of a uniform palette gives the largest distance
		if (theme == PAL_UNIFORM)
			map_pixel(~base);
		// halfway between two gray steps ties both neighbors
		if (theme == PAL_LADDER) begin
			step = $urandom_range(NUM_ENTRIES - 2);
			map_pixel({3{8'(step * 16 + 8)}});
		end
	endtask

	task automatic random_items(input int n);
		int   k;
		int   pick;
		int   a;
		int   b;
		rgb_t c;
		for (k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			a    = $urandom_range(NUM_ENTRIES - 1);
			b    = $urandom_range(NUM_ENTRIES - 1);
			if (pick < 2) begin
				reload_palette(pal_theme_e'($urandom_range(3)));
			end else if (pick < 10) begin
				// copying another entry makes duplicate colors, hence ties
				if ($urandom_range(2) == 0)
					c = shade[b];
				else
					c = 24'($urandom);
				load_entry(a[IDX_BITS-1:0], c);
			end else begin
				pick = $urandom_range(99);
				if (pick < 40) begin
					c = 24'($urandom);
				end else if (pick < 55) begin
					c.red   = $urandom_range(1) ? 8'hff : 8'h00;
					c.green = $urandom_range(1) ? 8'hff : 8'h00;
					c.blue  = $urandom_range(1) ? 8'hff : 8'h00;
				end else if (pick < 75) begin
					c = {nudge(shade[a].red), nudge(shade[a].green), nudge(shade[a].blue)};
				end else if (pick < 90) begin
					c = shade[a];
				end else begin
					c.red   = 8'((int'(shade[a].red) + int'(shade[b].red)) / 2);
					c.green = 8'((int'(shade[a].green) + int'(shade[b].green)) / 2);
					c.blue  = 8'((int'(shade[a].blue) + int'(shade[b].blue)) / 2);
				end
				map_pixel(c);
			end
		end
	endtask

	initial begin
		int   i;
		int   phase;
		rgb_t c;
		pixel.valid       <= 1'b0;
		pixel.action      <= ACT_LOAD;
		pixel.entry_index <= '0;
		pixel.red         <= '0;
		pixel.green       <= '0;
		pixel.blue        <= '0;
		hold_toggle       <= 1'b0;
		arst_n            <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every slot loaded before the first map: the eight cube corners, then
		// a duplicated mid gray and a few odd colors
		for (i = 0; i < 8; i++) begin
			c.red   = i[0] ? 8'hff : 8'h00;
			c.green = i[1] ? 8'hff : 8'h00;
			c.blue  = i[2] ? 8'hff : 8'h00;
			load_entry(i[IDX_BITS-1:0], c);
		end
		load_entry(4'd8, {8'd128, 8'd128, 8'd128});
		load_entry(4'd9, {8'd128, 8'd128, 8'd128});
		load_entry(4'd10, {8'd64, 8'd32, 8'd16});
		load_entry(4'd11, {8'd1, 8'd2, 8'd3});
		load_entry(4'd12, {8'd200, 8'd100, 8'd50});
		load_entry(4'd13, {8'd10, 8'd20, 8'd30});
		load_entry(4'd14, {8'd254, 8'd254, 8'd254});
		load_entry(4'd15, {8'd127, 8'd128, 8'd129});
		map_pixel({8'd0, 8'd0, 8'd0});
		map_pixel({8'd255, 8'd255, 8'd255});
		map_pixel({8'd128, 8'd128, 8'd128});
		map_pixel({8'd1, 8'd1, 8'd1});
		map_pixel({8'd255, 8'd0, 8'd128});
		map_pixel({8'd190, 8'd190, 8'd190});
		wait_drained;

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					idle_pct = 69;
					stall_pct <= 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct <= 69;
				end
				default: begin
					idle_pct = 27;
					stall_pct <= 27;
				end
			endcase
			random_items(210);
			wait_drained;

			// back-pressure: hold the result side while maps keep coming, so the
			// chain fills and the input stalls
			if (phase == 0) begin
				hold_toggle <= ~hold_toggle;
				for (i = 0; i < 90; i++)
					map_pixel(24'($urandom));
				wait_drained;
			end
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/npc_pkg.sv
hdl/npc_in_if.sv
hdl/npc_out_if.sv
hdl/npc_cell.sv
hdl/nearest_palette_color.sv
tb/npc_tb_pkg.sv
tb/npc_map_checker.sv
tb/tb_nearest_palette_color.sv
